### rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;
	localparam int CELL_W = 16;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

	typedef enum logic [1:0] {
		OP_PUT = 2'd0,
		OP_READ = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

endpackage

`default_nettype wire

### rtl/tcw_mem.sv
`default_nettype none

module tcw_mem import tcw_pkg::*; #(
	parameter int DEPTH = COLS_DEF * ROWS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [CELL_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output      logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem_q [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/text_console_writer_top.sv
`default_nettype none

// Text console engine: a ROWS x COLS cell memory (character in the low byte, attribute
// {bg, fg} in the high byte) plus a cursor. Op 0 puts a character (newline, line wrap and
// scroll handled), op 1 reads a cell, op 2 blanks the screen; every request returns one
// result carrying the read cell (zero otherwise) and the cursor after the request. The
// cell memory is not initialized by reset, so issue a clear before reading. One request
// is handled at a time and all work goes through the single write port of the cell
// memory: a put writes one cell, an in-range read passes through a read state, and a
// plain newline, an out-of-range read or an unused op 3 go straight to the result; a clear
// blanks every cell, and a newline on the bottom row scrolls the screen up and blanks the
// bottom row (one cell moved or blanked per cycle) before a wrapping put writes its
// character. A finished result waits in the output register while the next request is accepted.
module text_console_writer_top import tcw_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_index,
	input  wire logic [3:0] cfg_data,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [1:0] op,
	input  wire logic [7:0] char_code,
	input  wire logic [4:0] cell_row,
	input  wire logic [6:0] cell_col,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [7:0] cell_char,
	output      logic [7:0] cell_attr,
	output      logic [4:0] cursor_row,
	output      logic [6:0] cursor_col
);

	localparam int TOTAL = ROWS * COLS;
	localparam int AW = $clog2(TOTAL);
	localparam int CW = $clog2(TOTAL + 1);
	localparam int RW = $clog2(ROWS);
	localparam int CLW = $clog2(COLS + 1);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_READ   = 7'b0000010,
		ST_SCROLL = 7'b0000100,
		ST_BLANK  = 7'b0001000,
		ST_CLEAR  = 7'b0010000,
		ST_PUT    = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] cur_row_q;
	logic [CLW-1:0] cur_col_q;
	logic pend_put_q;
	logic [3:0] fg_q;
	logic [3:0] bg_q;
	logic out_valid_q;
	logic [7:0] ch_q;
	logic [7:0] res_char_q;
	logic [7:0] res_attr_q;
	logic [7:0] cell_char_q;
	logic [7:0] cell_attr_q;
	logic [4:0] cursor_row_q;
	logic [6:0] cursor_col_q;

	logic in_accept;
	logic out_load;
	logic rd_in_range;
	logic at_bottom;
	logic wrap_pending;
	logic [7:0] attr;
	logic [CELL_W-1:0] blank_cell;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] put_addr;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic mem_re;
	logic [AW-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	assign in_stall = (state_q != ST_IDLE);
	assign in_accept = in_valid && (state_q == ST_IDLE);
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	assign rd_in_range = (32'(cell_row) < ROWS) && (32'(cell_col) < COLS);
	assign at_bottom = (cur_row_q == RW'(ROWS - 1));
	assign wrap_pending = (cur_col_q == CLW'(COLS));
	assign attr = {bg_q, fg_q};
	assign blank_cell = {attr, BLANK_CHAR};
	assign rd_addr = AW'(AW'(cell_row) * AW'(COLS) + AW'(cell_col));
	assign put_addr = AW'(AW'(cur_row_q) * AW'(COLS) + AW'(cur_col_q));

	// memory port steering
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = blank_cell;
		mem_re = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				mem_re = in_accept && (op == OP_READ) && rd_in_range;
				mem_raddr = rd_addr;
			end
			ST_SCROLL: begin
				mem_re = (cnt_q != CW'(TOTAL));
				mem_raddr = cnt_q[AW-1:0];
				mem_we = (cnt_q != CW'(COLS));
				mem_waddr = AW'(cnt_q - CW'(COLS + 1));
				mem_wdata = mem_rdata;
			end
			ST_BLANK, ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
			end
			ST_PUT: begin
				mem_we = 1'b1;
				mem_waddr = put_addr;
				mem_wdata = {attr, ch_q};
			end
			ST_READ, ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	tcw_mem #(
		.DEPTH(TOTAL),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'hf;
			bg_q <= 4'h0;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_FG) begin
				fg_q <= cfg_data;
			end
			if (cfg_index == REG_BG) begin
				bg_q <= cfg_data;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
			pend_put_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_FINISH;
						if (op == OP_PUT) begin
							if (char_code == NEWLINE_CHAR || wrap_pending) begin
								cur_col_q <= '0;
								pend_put_q <= (char_code != NEWLINE_CHAR);
								if (at_bottom) begin
									cnt_q <= CW'(COLS);
									state_q <= ST_SCROLL;
								end else begin
									cur_row_q <= cur_row_q + RW'(1);
									if (char_code != NEWLINE_CHAR) begin
										state_q <= ST_PUT;
									end
								end
							end else begin
								state_q <= ST_PUT;
							end
						end else if (op == OP_READ) begin
							if (rd_in_range) begin
								state_q <= ST_READ;
							end
						end else if (op == OP_CLEAR) begin
							cnt_q <= '0;
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_SCROLL: begin
					if (cnt_q == CW'(TOTAL)) begin
						cnt_q <= CW'(TOTAL - COLS);
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_BLANK: begin
					if (cnt_q == CW'(TOTAL - 1)) begin
						state_q <= pend_put_q ? ST_PUT : ST_FINISH;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_CLEAR: begin
					if (cnt_q == CW'(TOTAL - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_PUT: begin
					cur_col_q <= cur_col_q + CLW'(1);
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ch_q <= char_code;
			res_char_q <= '0;
			res_attr_q <= '0;
		end
		if (state_q == ST_READ) begin
			res_char_q <= mem_rdata[7:0];
			res_attr_q <= mem_rdata[15:8];
		end
		if (out_load) begin
			cell_char_q <= res_char_q;
			cell_attr_q <= res_attr_q;
			cursor_row_q <= 5'(cur_row_q);
			cursor_col_q <= 7'(cur_col_q);
		end
	end

	assign out_valid = out_valid_q;
	assign cell_char = cell_char_q;
	assign cell_attr = cell_attr_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_row_q <= RW'(ROWS - 1))
		else $error("cursor row beyond bottom row");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q <= CLW'(COLS))
		else $error("cursor column beyond line end");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside finish");

	a_scroll_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && mem_we) |-> (mem_waddr < AW'(TOTAL - COLS)))
		else $error("scroll wrote into bottom row");

	a_put_col: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |-> (cur_col_q < CLW'(COLS)))
		else $error("character put past line end");

endmodule

`default_nettype wire
